// ===== sv/lrn_pkg.sv =====
// Shared types, widths and constant tables for the cross-channel LRN block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lrn_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int WS_W       = 4;
    localparam int PAD_W      = 3;
    localparam int ALPHA_W    = 24;
    localparam int BETA_W     = 16;
    localparam int K_W        = 16;
    localparam int SUM_W      = 35;
    localparam int S_W        = 36;
    localparam int FRAC_W     = 16;
    localparam int MANT_W     = 31;
    localparam int LOG_W      = 23;
    localparam int T_W        = 40;
    localparam int IDX_W      = 5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WINDOW_SIZE = 2'd0,
        CFG_ALPHA       = 2'd1,
        CFG_BETA        = 2'd2,
        CFG_K_OFFSET    = 2'd3
    } t_cfg_addr;

    typedef struct packed {
        logic [WS_W-1:0]    window_size;
        logic [ALPHA_W-1:0] alpha;
        logic [BETA_W-1:0]  beta;
        logic [K_W-1:0]     k_offset;
    } t_lrn_cfg;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef logic [FRAC_W-1:0][MANT_W-1:0] t_root_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] vv;
        r  = 64'd0;
        vv = v;
        b  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (vv >= r + b) begin
                vv = vv - (r + b);
                r  = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-j) in Q1.30 for j = 1..16, entry j-1
    function automatic t_root_tab exp_roots();
        t_root_tab   tab;
        logic [63:0] root;
        root = 64'd2 << 30;
        for (int j = 0; j < FRAC_W; j++) begin
            root   = isqrt64(root << 30);
            tab[j] = root[MANT_W-1:0];
        end
        return tab;
    endfunction

    localparam t_root_tab EXP_ROOTS = exp_roots();

endpackage

`default_nettype wire

// ===== sv/lrn_cell.sv =====
// One window cell: holds a sample and its square, and adds its square, when enabled,
// into the partial sum that runs down the chain every cycle. Uses lrn_pkg.
`default_nettype none

module lrn_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lrn_pkg::t_cell_ctl             i_ctl,
    input  logic                           i_en,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    input  logic [2*SAMPLE_BITS-1:0]       i_square,
    input  logic [lrn_pkg::SUM_W-1:0]      i_psum,
    output logic [SAMPLE_BITS-1:0]         o_sample,
    output logic [2*SAMPLE_BITS-1:0]       o_square,
    output logic [lrn_pkg::SUM_W-1:0]      o_psum
);
    import lrn_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_BITS;
    localparam int AW   = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SQ_W-1:0]        r_square;
    logic [SUM_W-1:0]       r_psum;
    logic [AW-1:0]          w_total;
    logic [SUM_W-1:0]       n_psum;

    // saturate at the top of the sum range
    assign w_total = AW'(i_psum) + (i_en ? AW'(r_square) : AW'(0));
    assign n_psum  = (w_total > AW'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : w_total[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
            r_square <= '0;
            r_psum   <= '0;
        end else begin
            r_psum <= n_psum;
            if (i_ctl.clear) begin
                r_sample <= '0;
                r_square <= '0;
            end else if (i_ctl.shift) begin
                r_sample <= i_sample;
                r_square <= i_square;
            end
        end
    end

    assign o_sample = r_sample;
    assign o_square = r_square;
    assign o_psum   = r_psum;

endmodule

`default_nettype wire

// ===== sv/lrn_norm.sv =====
// Normalizer: y = x * (k + alpha*sum)^(-beta) through iterative log2,
// one beta multiply, iterative exp2 and a final scale. Uses lrn_pkg.
`default_nettype none

module lrn_norm #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrn_pkg::t_lrn_cfg             i_cfg,
    input  logic                          i_start,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic [lrn_pkg::SUM_W-1:0]     i_sum,
    input  logic                          i_take,
    output logic                          o_valid,
    output logic [SAMPLE_BITS-1:0]        o_result
);
    import lrn_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int LO_W = 18;
    localparam int HI_W = SUM_W - LO_W;
    localparam int PRW  = ALPHA_W + SUM_W;
    localparam int PW   = SB + MANT_W;

    typedef enum logic [3:0] {
        N_IDLE, N_MLO, N_MHI, N_ADD, N_NORM, N_LOG, N_BETA, N_EXP, N_FMUL, N_SHF, N_FIN
    } t_state;

    t_state                    r_state;
    logic                      r_neg;
    logic [SB-1:0]             r_mag;
    logic [SUM_W-1:0]          r_sum;
    logic [ALPHA_W+LO_W-1:0]   r_pa;
    logic [ALPHA_W+HI_W-1:0]   r_pb;
    logic [S_W-1:0]            r_s;
    logic [5:0]                r_e;
    logic [MANT_W-1:0]         r_m;
    logic [FRAC_W-1:0]         r_frac;
    logic [3:0]                r_cnt;
    logic signed [T_W-1:0]     r_t;
    logic [MANT_W-1:0]         r_acc;
    logic [PW-1:0]             r_prod;
    logic [SB-1:0]             r_res;

    logic [PRW-1:0]            w_prod_all;
    logic [S_W-1:0]            n_s;
    logic [2*MANT_W-1:0]       w_msq;
    logic signed [LOG_W-1:0]   w_l;
    logic signed [T_W-1:0]     w_bl;
    logic signed [9:0]         w_n;
    logic [FRAC_W-1:0]         w_f;
    logic [2*MANT_W-1:0]       w_amul;
    logic signed [10:0]        w_sh;
    logic [10:0]               w_ls;
    logic [PW-1:0]             w_r;
    logic                      w_over;
    logic [SB-1:0]             w_lim;
    logic [SB-1:0]             w_omag;
    logic [SB-1:0]             n_res;
    logic [SB-1:0]             n_spec;
    logic                      w_in_neg;

    assign w_in_neg   = i_sample[SB-1];
    assign w_prod_all = PRW'(r_pa) + (PRW'(r_pb) << LO_W);
    assign n_s        = S_W'({i_cfg.k_offset, 8'd0}) + S_W'(w_prod_all >> 24);
    assign w_msq      = r_m * r_m;
    assign w_l        = $signed({7'({1'b0, r_e}) - 7'd16, r_frac});
    assign w_bl       = $signed({1'b0, i_cfg.beta}) * w_l;
    assign w_n        = r_t[T_W-1:30];
    assign w_f        = r_t[29:14];
    assign w_amul     = r_acc * EXP_ROOTS[r_cnt];
    assign w_sh       = 11'sd30 - 11'(w_n);
    assign w_ls       = 11'(-w_sh);
    assign w_lim      = {r_neg, {(SB-1){~r_neg}}};

    // scale by 2^n and clamp to the signed output range
    always_comb begin
        w_r    = '0;
        w_over = 1'b0;
        if (!w_sh[10]) begin
            if ($unsigned(w_sh) >= 11'(PW)) begin
                w_r = '0;
            end else begin
                w_r = r_prod >> w_sh;
            end
            w_over = (w_r > PW'(w_lim));
        end else begin
            w_r = r_prod << w_ls;
            if (w_ls >= 11'(SB)) begin
                w_over = (r_prod != '0);
            end else begin
                w_over = (r_prod > ((PW'(1) << (SB - 1)) >> w_ls)) || (w_r > PW'(w_lim));
            end
        end
        w_omag = w_over ? w_lim : w_r[SB-1:0];
        n_res  = r_neg ? SB'(SB'(0) - w_omag) : w_omag;
    end

    // zero denominator: pass x through for beta zero or x zero, else saturate
    assign n_spec = ((i_cfg.beta == '0) || (r_mag == '0))
                  ? (r_neg ? SB'(SB'(0) - r_mag) : r_mag)
                  : (r_neg ? SB'(SB'(0) - w_lim) : w_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_neg   <= w_in_neg;
                        r_mag   <= w_in_neg ? SB'(SB'(0) - i_sample) : i_sample;
                        r_sum   <= i_sum;
                        r_state <= N_MLO;
                    end
                end
                N_MLO: begin
                    r_pa    <= i_cfg.alpha * r_sum[LO_W-1:0];
                    r_state <= N_MHI;
                end
                N_MHI: begin
                    r_pb    <= i_cfg.alpha * r_sum[SUM_W-1:LO_W];
                    r_state <= N_ADD;
                end
                N_ADD: begin
                    r_s     <= n_s;
                    r_e     <= 6'(S_W - 1);
                    r_state <= N_NORM;
                end
                N_NORM: begin
                    if (r_s == '0) begin
                        r_res   <= n_spec;
                        r_state <= N_FIN;
                    end else if (!r_s[S_W-1]) begin
                        r_s <= r_s << 1;
                        r_e <= r_e - 6'd1;
                    end else begin
                        r_m     <= r_s[S_W-1 -: MANT_W];
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_state <= N_LOG;
                    end
                end
                N_LOG: begin
                    // square the mantissa, take one fraction bit
                    if (w_msq[2*MANT_W-1]) begin
                        r_m    <= w_msq[2*MANT_W-1 -: MANT_W];
                        r_frac <= {r_frac[FRAC_W-2:0], 1'b1};
                    end else begin
                        r_m    <= w_msq[2*MANT_W-2 -: MANT_W];
                        r_frac <= {r_frac[FRAC_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(FRAC_W - 1)) begin
                        r_state <= N_BETA;
                    end
                end
                N_BETA: begin
                    r_t     <= -w_bl;
                    r_acc   <= MANT_W'(1) << 30;
                    r_cnt   <= '0;
                    r_state <= N_EXP;
                end
                N_EXP: begin
                    if (w_f[~r_cnt]) begin
                        r_acc <= w_amul[60:30];
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(FRAC_W - 1)) begin
                        r_state <= N_FMUL;
                    end
                end
                N_FMUL: begin
                    r_prod  <= r_mag * r_acc;
                    r_state <= N_SHF;
                end
                N_SHF: begin
                    r_res   <= n_res;
                    r_state <= N_FIN;
                end
                N_FIN: begin
                    if (i_take) begin
                        r_state <= N_IDLE;
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_valid  = (r_state == N_FIN);
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== sv/lrn_cross_channel_forward.sv =====
// Top level of the cross-channel LRN block: window cell chain, sequencer,
// normalizer and output register. Uses lrn_pkg, lrn_cell, lrn_norm.
//
//   channel   direction  beats                        payload
//   s_axis    in         one per channel sample       tdata: sample; tlast: last_channel
//   m_axis    out        0..pad+1 per input sample    tdata: normalized; tlast: last_output
//   cfg       in         one per register write       addr: register index; data: value
//
// Each result is computed after the transfer or flush step that causes it: the sum settles
// down the cell chain, then the normalizer runs the leading-one shift, the log2 squarings,
// the exp2 products and the final scale, and hands the result to the output register. For a
// zero denominator the normalizer skips the log2 and exp2 steps.
// One sample is worked on at a time.
// Reset is synchronous, active low; it clears the window and restores register defaults.
// A full output register stalls the normalizer; input is taken again once all results
// of the previous sample have been handed to the output register.
`default_nettype none

module lrn_cross_channel_forward #(
    parameter int MAX_WINDOW  = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [SAMPLE_BITS-1:0] sample, rest zero
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [SAMPLE_BITS-1:0] normalized, rest zero
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
    output logic                                   m_axis_tlast,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lrn_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [lrn_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import lrn_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int TD_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PAD_MAX = (MAX_WINDOW - 1) / 2;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);

    typedef enum logic [2:0] {T_IDLE, T_SUM, T_GO, T_WAIT, T_NEXT} t_state;

    t_state              r_state;
    t_lrn_cfg            r_cfg;
    logic [PAD_W-1:0]    r_pad;
    logic [PAD_W-1:0]    r_j;
    logic                r_last;
    logic                r_emit_last;
    logic [IDX_W-1:0]    r_chan;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [SB-1:0]       r_out_data;
    logic                r_out_last;

    t_cell_ctl           w_ctl;
    logic                w_accept;
    logic                w_flush;
    logic [PAD_W-1:0]    w_pad_new;
    logic [SB-1:0]       w_in_sample;
    logic [SB-1:0]       w_in_mag;
    logic [2*SB-1:0]     w_in_sq;
    logic [SB-1:0]       w_center;
    logic                w_norm_valid;
    logic [SB-1:0]       w_norm_res;
    logic                w_take;
    logic [SB-1:0]       w_samp [MAX_WINDOW];
    logic [2*SB-1:0]     w_sq   [MAX_WINDOW];
    logic [SUM_W-1:0]    w_psum [MAX_WINDOW];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_size <= WS_W'(5);
            r_cfg.alpha       <= ALPHA_W'(3355443);
            r_cfg.beta        <= BETA_W'(12288);
            r_cfg.k_offset    <= K_W'(256);
        end else if (i_cfg_valid) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_WINDOW_SIZE: r_cfg.window_size <= i_cfg_data[WS_W-1:0];
                CFG_ALPHA:       r_cfg.alpha       <= i_cfg_data[ALPHA_W-1:0];
                CFG_BETA:        r_cfg.beta        <= i_cfg_data[BETA_W-1:0];
                CFG_K_OFFSET:    r_cfg.k_offset    <= i_cfg_data[K_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == T_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_flush       = (r_state == T_NEXT) && r_last && (r_j < r_pad);

    assign w_pad_new = (int'(r_cfg.window_size[WS_W-1:1]) > PAD_MAX)
                     ? PAD_W'(PAD_MAX) : r_cfg.window_size[WS_W-1:1];

    // flush shifts zeros into the window
    assign w_in_sample = (r_state == T_IDLE) ? s_axis_tdata[SB-1:0] : '0;
    assign w_in_mag    = w_in_sample[SB-1] ? SB'(SB'(0) - w_in_sample) : w_in_sample;
    assign w_in_sq     = w_in_mag * w_in_mag;

    assign w_ctl.shift = w_accept || w_flush;
    assign w_ctl.clear = (r_state == T_NEXT) && r_last && !(r_j < r_pad);

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        if (i == 0) begin : g_head
            lrn_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_en     (1'b1),
                .i_sample (w_in_sample),
                .i_square (w_in_sq),
                .i_psum   ({SUM_W{1'b0}}),
                .o_sample (w_samp[i]),
                .o_square (w_sq[i]),
                .o_psum   (w_psum[i])
            );
        end else begin : g_body
            lrn_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_en     (i <= 2 * int'(r_pad)),
                .i_sample (w_samp[i-1]),
                .i_square (w_sq[i-1]),
                .i_psum   (w_psum[i-1]),
                .o_sample (w_samp[i]),
                .o_square (w_sq[i]),
                .o_psum   (w_psum[i])
            );
        end
    end

    always_comb begin
        w_center = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (int'(r_pad) == i) begin
                w_center = w_samp[i];
            end
        end
    end

    lrn_norm #(.SAMPLE_BITS(SAMPLE_BITS)) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (r_state == T_GO),
        .i_sample (w_center),
        .i_sum    (w_psum[MAX_WINDOW-1]),
        .i_take   (w_take),
        .o_valid  (w_norm_valid),
        .o_result (w_norm_res)
    );

    assign w_take = w_norm_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_pad       <= '0;
            r_j         <= '0;
            r_last      <= 1'b0;
            r_emit_last <= 1'b0;
            r_chan      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                r_out_data  <= w_norm_res;
                r_out_last  <= r_emit_last;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        r_pad       <= w_pad_new;
                        r_last      <= s_axis_tlast;
                        r_j         <= '0;
                        r_emit_last <= s_axis_tlast && (w_pad_new == '0);
                        r_cnt       <= '0;
                        r_state     <= (r_chan >= IDX_W'(w_pad_new)) ? T_SUM : T_NEXT;
                    end
                end
                T_SUM: begin
                    // wait for the partial sum to reach the end of the chain
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MAX_WINDOW - 1)) begin
                        r_state <= T_GO;
                    end
                end
                T_GO: begin
                    r_state <= T_WAIT;
                end
                T_WAIT: begin
                    if (w_take) begin
                        r_state <= T_NEXT;
                    end
                end
                T_NEXT: begin
                    if (w_flush) begin
                        r_j <= r_j + PAD_W'(1);
                        if ((6'(r_chan) + 6'(r_j) + 6'd1) >= 6'(r_pad)) begin
                            r_emit_last <= ((r_j + PAD_W'(1)) == r_pad);
                            r_cnt       <= '0;
                            r_state     <= T_SUM;
                        end
                    end else begin
                        if (r_last) begin
                            r_chan <= '0;
                        end else if (r_chan != {IDX_W{1'b1}}) begin
                            r_chan <= r_chan + IDX_W'(1);
                        end
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TD_W'(r_out_data);
    assign m_axis_tlast  = r_out_last;

    a_norm_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_norm_valid |-> (r_state == T_WAIT))
        else $error("normalizer result outside wait state");

    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j <= r_pad)
        else $error("flush count beyond window half width");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != T_IDLE))
        else $error("sequencer stayed idle after an input transfer");

endmodule

`default_nettype wire
